// ----- src/tccs_pkg.sv -----
// Shared types and constants for the text console cursor and scroll controller.
package tccs_pkg;

  localparam int unsigned CMD_MAX = 5;
  localparam int unsigned CNT_W   = $clog2(CMD_MAX + 1);
  localparam int unsigned ROW_W   = 7;
  localparam int unsigned COL_W   = 8;
  localparam int unsigned GLY_W   = 8;
  localparam int unsigned OFF_W   = 19;
  localparam int unsigned ROWS_W  = 6;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned TDATA_W = 48;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned APB_W   = 32;

  localparam logic [CHAR_W-1:0] CHAR_BS = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_LF = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR = 8'd13;

  localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 8'd32;
  localparam logic [CHAR_W-1:0] LAST_PRINTABLE  = 8'd126;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_STEP    = 2'd2;

  localparam logic [COL_W-1:0]  COLUMNS_RST = 8'd80;
  localparam logic [ROWS_W-1:0] ROWS_RST    = 6'd30;
  localparam logic [STEP_W-1:0] STEP_RST    = 16'd10240;

  typedef enum logic [1:0] {
    OP_DRAW      = 2'd0,
    OP_CLEAR_ROW = 2'd1,
    OP_CLEAR_ALL = 2'd2,
    OP_SET_START = 2'd3
  } op_e;

  typedef struct packed {
    logic [OFF_W-1:0] display_offset;
    logic [GLY_W-1:0] glyph_index;
    logic [COL_W-1:0] text_column;
    logic [ROW_W-1:0] text_row;
    op_e              operation;
  } cmd_t;

  typedef cmd_t cmd_list_t [CMD_MAX];

  typedef struct packed {
    logic [COL_W-1:0]  columns;
    logic [ROWS_W-1:0] rows;
    logic [STEP_W-1:0] step;
  } cfg_t;

endpackage

// ----- src/tccs_cursor.sv -----
// Cursor and display start state with the per-character command builder.
module tccs_cursor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tccs_pkg::cfg_t                cfg_i,
  input  logic                          load_i,
  input  logic [tccs_pkg::CHAR_W-1:0]   char_i,
  output tccs_pkg::cmd_list_t           cmds_o,
  output logic [tccs_pkg::CNT_W-1:0]    count_o
);

  logic [tccs_pkg::ROW_W-1:0] row_q, row_d;
  logic [tccs_pkg::COL_W-1:0] col_q, col_d;
  logic [tccs_pkg::OFF_W-1:0] off_q, off_d;

  logic [tccs_pkg::ROW_W-1:0] r1;
  logic [tccs_pkg::ROW_W-1:0] rows_ext;
  logic [tccs_pkg::ROW_W-1:0] rows_dbl;
  logic [tccs_pkg::COL_W:0]   col_inc;
  logic [tccs_pkg::CNT_W-1:0] n;
  logic                       do_scroll;

  assign rows_ext = {1'b0, cfg_i.rows};
  assign rows_dbl = {cfg_i.rows, 1'b0};
  assign col_inc  = {1'b0, col_q} + 9'd1;

  always_comb begin
    row_d     = row_q;
    col_d     = col_q;
    off_d     = off_q;
    n         = '0;
    do_scroll = 1'b0;
    r1        = '0;
    for (int i = 0; i < tccs_pkg::CMD_MAX; i++) begin
      cmds_o[i] = '0;
    end

    case (char_i)
      tccs_pkg::CHAR_CR: begin
        col_d = '0;
      end
      tccs_pkg::CHAR_LF: begin
        col_d     = '0;
        do_scroll = 1'b1;
      end
      tccs_pkg::CHAR_BS: begin
        if (col_q == '0) begin
          if (row_q != '0) begin
            row_d = row_q - 7'd1;
          end
          col_d = cfg_i.columns - 8'd1;
        end else begin
          col_d = col_q - 8'd1;
        end
        // erase at the new cursor
        cmds_o[0].operation   = tccs_pkg::OP_DRAW;
        cmds_o[0].text_row    = row_d;
        cmds_o[0].text_column = col_d;
        n = 3'd1;
      end
      default: begin
        if (char_i inside {[tccs_pkg::FIRST_PRINTABLE:tccs_pkg::LAST_PRINTABLE]}) begin
          cmds_o[0].operation   = tccs_pkg::OP_DRAW;
          cmds_o[0].text_row    = row_q;
          cmds_o[0].text_column = col_q;
          cmds_o[0].glyph_index = char_i - tccs_pkg::FIRST_PRINTABLE;
          n = 3'd1;
          if (col_inc >= {1'b0, cfg_i.columns}) begin
            col_d     = '0;
            do_scroll = 1'b1;
          end else begin
            col_d = col_inc[tccs_pkg::COL_W-1:0];
          end
        end
      end
    endcase

    if (do_scroll) begin
      r1    = row_d + 7'd1;
      row_d = r1;
      cmds_o[n].operation = tccs_pkg::OP_CLEAR_ROW;
      cmds_o[n].text_row  = r1;
      n = n + 3'd1;
      if (r1 >= rows_ext) begin
        // clear the row one screen above as well
        cmds_o[n].operation = tccs_pkg::OP_CLEAR_ROW;
        cmds_o[n].text_row  = r1 - rows_ext;
        n = n + 3'd1;
        if (r1 >= rows_dbl) begin
          row_d = '0;
          off_d = '0;
          cmds_o[n].operation = tccs_pkg::OP_CLEAR_ALL;
          n = n + 3'd1;
        end else begin
          off_d = off_q + {3'b000, cfg_i.step};
        end
        cmds_o[n].operation      = tccs_pkg::OP_SET_START;
        cmds_o[n].display_offset = off_d;
        n = n + 3'd1;
      end
    end
  end

  assign count_o = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      off_q <= '0;
    end else if (load_i) begin
      row_q <= row_d;
      col_q <= col_d;
      off_q <= off_d;
    end
  end

endmodule

// ----- src/tccs_cmd_queue.sv -----
// Command queue for one character's commands, drained into the output register.
module tccs_cmd_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  tccs_pkg::cmd_list_t         cmds_i,
  input  logic [tccs_pkg::CNT_W-1:0]  count_i,
  output logic                        free_o,
  output logic [tccs_pkg::CNT_W-1:0]  level_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output tccs_pkg::cmd_t              cmd_o,
  output logic                        last_o
);

  tccs_pkg::cmd_t             q_q [tccs_pkg::CMD_MAX];
  logic [tccs_pkg::CNT_W-1:0] cnt_q;
  logic                       valid_q;
  logic                       last_q;
  tccs_pkg::cmd_t             cmd_q;
  logic                       pop;

  assign pop    = (cnt_q != '0) && (!valid_q || ready_i);
  assign free_o = (cnt_q == '0) || ((cnt_q == 3'd1) && pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        cnt_q <= count_i;
      end else if (pop) begin
        cnt_q <= cnt_q - 3'd1;
      end
      if (pop) begin
        valid_q <= 1'b1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // payload: load a fresh list, or shift one word toward the head
  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q  <= q_q[0];
      last_q <= (cnt_q == 3'd1);
    end
    if (load_i) begin
      for (int i = 0; i < tccs_pkg::CMD_MAX; i++) begin
        q_q[i] <= cmds_i[i];
      end
    end else if (pop) begin
      for (int i = 0; i < tccs_pkg::CMD_MAX - 1; i++) begin
        q_q[i] <= q_q[i+1];
      end
    end
  end

  assign level_o = cnt_q;
  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;
  assign last_o  = last_q;

endmodule

// ----- src/text_console_cursor_scroll_top.sv -----
// Top level of the text console cursor and scroll controller.
// Each character word is registered, decoded combinationally against the cursor state into
// zero to five drawing commands, and the commands leave one per cycle through an output
// register while m_axis_tready_i is high; tlast marks the final command of a character.
// The next character loads into the command queue in the cycle its predecessor's last
// command moves to the output register. A character passes through the input register
// and the command queue before its first command reaches the output register.
// Configuration registers: 0x0 columns per screen, 0x4 rows per screen, 0x8 display
// start step per text row; write them only while the block is idle.
module text_console_cursor_scroll_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [tccs_pkg::CHAR_W-1:0]    s_axis_tdata_i,   // [7:0] character
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [1:0] operation, [8:2] text_row, [16:9] text_column, [24:17] glyph_index,
  // [43:25] display_offset, [47:44] zero
  output logic [tccs_pkg::TDATA_W-1:0]   m_axis_tdata_o,
  output logic                           m_axis_tlast_o,   // last_of_run
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tccs_pkg::ADDR_W-1:0]    paddr,
  input  logic [tccs_pkg::APB_W-1:0]     pwdata,
  output logic [tccs_pkg::APB_W-1:0]     prdata,
  output logic                           pready
);

  tccs_pkg::cfg_t               cfg_q;
  logic                         in_valid_q;
  logic [tccs_pkg::CHAR_W-1:0]  char_q;
  logic                         load;
  logic                         q_free;
  logic [tccs_pkg::CNT_W-1:0]   q_level;
  tccs_pkg::cmd_list_t          cmds;
  logic [tccs_pkg::CNT_W-1:0]   cmd_count;
  tccs_pkg::cmd_t               out_cmd;
  logic                         wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.columns <= tccs_pkg::COLUMNS_RST;
      cfg_q.rows    <= tccs_pkg::ROWS_RST;
      cfg_q.step    <= tccs_pkg::STEP_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        tccs_pkg::REG_COLUMNS: cfg_q.columns <= pwdata[tccs_pkg::COL_W-1:0];
        tccs_pkg::REG_ROWS:    cfg_q.rows    <= pwdata[tccs_pkg::ROWS_W-1:0];
        tccs_pkg::REG_STEP:    cfg_q.step    <= pwdata[tccs_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tccs_pkg::REG_COLUMNS: prdata = {24'd0, cfg_q.columns};
      tccs_pkg::REG_ROWS:    prdata = {26'd0, cfg_q.rows};
      tccs_pkg::REG_STEP:    prdata = {16'd0, cfg_q.step};
      default:               prdata = '0;
    endcase
  end

  // input register: hold the character until the queue takes its commands
  assign load            = in_valid_q && q_free;
  assign s_axis_tready_o = !in_valid_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      char_q <= s_axis_tdata_i;
    end
  end

  tccs_cursor u_cursor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .load_i  (load),
    .char_i  (char_q),
    .cmds_o  (cmds),
    .count_o (cmd_count)
  );

  tccs_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .cmds_i  (cmds),
    .count_i (cmd_count),
    .free_o  (q_free),
    .level_o (q_level),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .cmd_o   (out_cmd),
    .last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'd0, out_cmd};

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= 3'd5)
    else $error("command queue level out of range");

  a_load_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (q_level <= 3'd1))
    else $error("character loaded over pending commands");

  a_stall_holds_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q)
    else $error("input stalled with empty input register");

endmodule
